### hw/rtl/vbs_pkg.sv
// vbs_pkg: shared constants and types for the value bloom sketch.
// No dependencies.
package vbs_pkg;

   localparam logic [31:0] MIX_MUL = 32'h5bd1e995;
   localparam int WIDTH_W = 11;   // row_width register
   localparam int ROWS_W  = 4;    // row_count register
   localparam int LEN_W   = 4;    // key_len field

   localparam logic REQ_ADD   = 1'b0;
   localparam logic REQ_QUERY = 1'b1;

   localparam logic REG_ROW_WIDTH = 1'b0;
   localparam logic REG_ROW_COUNT = 1'b1;

   typedef struct packed {
      logic              start;
      logic [ROWS_W-1:0] seed;
      logic [LEN_W-1:0]  len;
   } hash_req_type;

   typedef struct packed {
      logic        done;
      logic [31:0] value;
   } hash_rsp_type;

endpackage

### hw/rtl/vbs_hash.sv
// vbs_hash: iterative 32-bit MurmurHash2 over a key of up to eight bytes.
// One shared 32x32 multiplier, one multiply per cycle. Depends on vbs_pkg.
module vbs_hash (
   input  logic                  clock,
   input  logic                  reset,
   input  vbs_pkg::hash_req_type hreq,
   input  logic [63:0]           key,
   output vbs_pkg::hash_rsp_type hrsp
);
   import vbs_pkg::*;

   typedef enum logic [2:0] {H_IDLE, H_K1, H_K2, H_HB, H_TAIL, H_F1, H_F2} hstate_type;

   hstate_type        state_ff;
   logic [31:0]       h_ff, k_ff;
   logic [LEN_W-1:0]  rem_ff;
   logic              blk_ff;
   logic              done_ff;

   logic [31:0] word, tail, mul_a, prod;
   logic [LEN_W-1:0] rem_next;

   assign word = blk_ff ? key[63:32] : key[31:0];
   assign tail = word & {8'h00, (rem_ff >= LEN_W'(3)) ? 8'hff : 8'h00,
                         (rem_ff >= LEN_W'(2)) ? 8'hff : 8'h00, 8'hff};
   assign rem_next = rem_ff - LEN_W'(4);

   always_comb begin
      unique case (state_ff)
         H_K1:    mul_a = word;
         H_K2:    mul_a = k_ff ^ (k_ff >> 24);
         H_HB:    mul_a = h_ff;
         H_TAIL:  mul_a = h_ff ^ tail;
         H_F1:    mul_a = h_ff ^ (h_ff >> 13);
         default: mul_a = h_ff;
      endcase
   end

   assign prod = mul_a * MIX_MUL;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= H_IDLE;
         done_ff  <= 1'b0;
      end else begin
         done_ff <= (state_ff == H_F2);
         unique case (state_ff)
            H_IDLE: begin
               if (hreq.start) begin
                  h_ff   <= {28'd0, hreq.seed} ^ {28'd0, hreq.len};
                  rem_ff <= hreq.len;
                  blk_ff <= 1'b0;
                  if (hreq.len >= LEN_W'(4))      state_ff <= H_K1;
                  else if (hreq.len != '0)        state_ff <= H_TAIL;
                  else                            state_ff <= H_F1;
               end
            end
            H_K1: begin
               k_ff     <= prod;
               state_ff <= H_K2;
            end
            H_K2: begin
               k_ff     <= prod;
               state_ff <= H_HB;
            end
            H_HB: begin
               h_ff   <= prod ^ k_ff;
               rem_ff <= rem_next;
               blk_ff <= 1'b1;
               if (rem_next >= LEN_W'(4))  state_ff <= H_K1;
               else if (rem_next != '0)    state_ff <= H_TAIL;
               else                        state_ff <= H_F1;
            end
            H_TAIL: begin
               h_ff     <= prod;
               state_ff <= H_F1;
            end
            H_F1: begin
               h_ff     <= prod;
               state_ff <= H_F2;
            end
            H_F2: begin
               h_ff     <= h_ff ^ (h_ff >> 15);
               state_ff <= H_IDLE;
            end
            default: state_ff <= H_IDLE;
         endcase
      end
   end

   assign hrsp.done  = done_ff;
   assign hrsp.value = h_ff;

endmodule

### hw/rtl/vbs_mod.sv
// vbs_mod: bit-serial remainder of a 32-bit hash by an 11-bit row width.
// Restoring scheme, one dividend bit per cycle. Depends on vbs_pkg.
module vbs_mod (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [31:0]                 dividend,
   input  logic [vbs_pkg::WIDTH_W-1:0] divisor,
   output logic                        done,
   output logic [vbs_pkg::WIDTH_W-1:0] remainder
);
   import vbs_pkg::*;

   logic [31:0]        dvd_ff;
   logic [WIDTH_W-1:0] rem_ff;
   logic [5:0]         cnt_ff;
   logic               busy_ff, done_ff;
   logic [WIDTH_W:0]   trial;

   assign trial = {rem_ff, dvd_ff[31]};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= !start && busy_ff && (cnt_ff == 6'd1);
         if (start) begin
            dvd_ff  <= dividend;
            rem_ff  <= '0;
            cnt_ff  <= 6'd32;
            busy_ff <= 1'b1;
         end else if (busy_ff) begin
            dvd_ff <= {dvd_ff[30:0], 1'b0};
            if (trial >= {1'b0, divisor}) rem_ff <= WIDTH_W'(trial - {1'b0, divisor});
            else                          rem_ff <= trial[WIDTH_W-1:0];
            cnt_ff <= cnt_ff - 6'd1;
            if (cnt_ff == 6'd1) busy_ff <= 1'b0;
         end
      end
   end

   assign done      = done_ff;
   assign remainder = rem_ff;

endmodule

### hw/rtl/value_bloom_sketch.sv
// Sequence: each row in use goes through a row step, the hash, the modulo reduction,
// then a read and an update; after the last row the result is issued.
// Throughput: one item at a time; the bit-serial modulo unit dominates each row.
// Reset: synchronous; after reset a clearing pass zeroes every store entry,
// req_ready staying low meanwhile. Registers reset to width 1024, 8 rows.
module value_bloom_sketch #(
   parameter int ROW_ENTRIES = 1024,
   parameter int ROWS        = 8,
   parameter int KEY_BYTES   = 8
) (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_type,
   input  logic [63:0] req_key,
   input  logic [3:0]  req_key_len,
   input  logic [31:0] req_value,
   // result channel
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [31:0] rsp_result_value,
   // register port
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [2:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);
   import vbs_pkg::*;

   localparam int STORE = ROWS * ROW_ENTRIES;
   localparam int AW    = (STORE > 1) ? $clog2(STORE) : 1;
   localparam int W_CAP = (ROW_ENTRIES > 2047) ? 2047 : ROW_ENTRIES;
   localparam int R_CAP = (ROWS > 15) ? 15 : ROWS;

   typedef enum logic [2:0] {S_CLEAR, S_IDLE, S_ROW, S_HASH, S_DIV, S_READ, S_UPD, S_DONE}
      state_type;

   // configuration
   logic [WIDTH_W-1:0] row_width_ff;
   logic [ROWS_W-1:0]  row_count_ff;

   // per-item state
   state_type          state_ff;
   logic               query_ff;
   logic [63:0]        key_ff;
   logic [LEN_W-1:0]   len_ff;
   logic [31:0]        value_ff;
   logic [WIDTH_W-1:0] w_ff;
   logic [ROWS_W-1:0]  rows_ff, row_ff;
   logic [AW-1:0]      base_ff, addr_ff, clr_ff;
   logic [31:0]        acc_ff;
   logic               rsp_valid_ff;
   logic [31:0]        rsp_value_ff;

   // store
   logic [31:0]        mem [STORE];
   logic [31:0]        rd_ff;
   logic               mem_we;
   logic [AW-1:0]      mem_addr;
   logic [31:0]        mem_wdata;

   // clamped settings, taken at accept
   logic [WIDTH_W-1:0] w_in;
   logic [ROWS_W-1:0]  rows_in;
   logic [LEN_W-1:0]   len_in;

   hash_req_type       hreq;
   hash_rsp_type       hrsp;
   logic               div_start, div_done;
   logic [WIDTH_W-1:0] col;

   logic csr_write, req_accept, rsp_take;

   assign csr_write  = psel & penable & pwrite;
   assign pready     = 1'b1;
   assign prdata     = (paddr[2] == REG_ROW_COUNT) ? {28'd0, row_count_ff}
                                                   : {21'd0, row_width_ff};
   assign req_ready  = (state_ff == S_IDLE);
   assign req_accept = req_valid & req_ready;
   assign rsp_take   = rsp_valid_ff & rsp_ready;

   always_comb begin
      if (row_width_ff == '0)                  w_in = WIDTH_W'(1);
      else if (int'(row_width_ff) > W_CAP)     w_in = WIDTH_W'(W_CAP);
      else                                     w_in = row_width_ff;
      rows_in = (int'(row_count_ff) > R_CAP) ? ROWS_W'(R_CAP) : row_count_ff;
      len_in  = (int'(req_key_len) > KEY_BYTES) ? LEN_W'(KEY_BYTES) : req_key_len;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_width_ff <= WIDTH_W'(1024);
         row_count_ff <= ROWS_W'(8);
      end else if (csr_write) begin
         if (paddr[2] == REG_ROW_WIDTH) row_width_ff <= pwdata[WIDTH_W-1:0];
         else                           row_count_ff <= pwdata[ROWS_W-1:0];
      end
   end

   // one row at a time: hash, reduce modulo width, read, then OR in or AND into acc
   assign hreq.start = (state_ff == S_ROW) && (row_ff < rows_ff);
   assign hreq.seed  = row_ff;
   assign hreq.len   = len_ff;
   assign div_start  = (state_ff == S_HASH) && hrsp.done;

   vbs_hash u_hash (
      .clock (clock),
      .reset (reset),
      .hreq  (hreq),
      .key   (key_ff),
      .hrsp  (hrsp)
   );

   vbs_mod u_mod (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (hrsp.value),
      .divisor   (w_ff),
      .done      (div_done),
      .remainder (col)
   );

   always_comb begin
      mem_we    = (state_ff == S_CLEAR) || ((state_ff == S_UPD) && (query_ff == REQ_ADD));
      mem_addr  = (state_ff == S_CLEAR) ? clr_ff : addr_ff;
      mem_wdata = (state_ff == S_CLEAR) ? 32'd0 : (rd_ff | value_ff);
   end

   always_ff @(posedge clock) begin
      if (mem_we) mem[mem_addr] <= mem_wdata;
      rd_ff <= mem[mem_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         // in S_DONE the result register is refilled below
         if (rsp_take && (state_ff != S_DONE)) rsp_valid_ff <= 1'b0;
         unique case (state_ff)
            S_CLEAR: begin
               clr_ff <= clr_ff + AW'(1);
               if (clr_ff == AW'(STORE - 1)) state_ff <= S_IDLE;
            end
            S_IDLE: begin
               if (req_accept) begin
                  query_ff <= req_type;
                  key_ff   <= req_key;
                  len_ff   <= len_in;
                  value_ff <= req_value;
                  w_ff     <= w_in;
                  rows_ff  <= rows_in;
                  row_ff   <= '0;
                  base_ff  <= '0;
                  acc_ff   <= 32'hffff_ffff;
                  state_ff <= S_ROW;
               end
            end
            S_ROW: begin
               state_ff <= (row_ff < rows_ff) ? S_HASH : S_DONE;
            end
            S_HASH: begin
               if (hrsp.done) state_ff <= S_DIV;
            end
            S_DIV: begin
               if (div_done) begin
                  addr_ff  <= base_ff + AW'(col);
                  state_ff <= S_READ;
               end
            end
            S_READ: state_ff <= S_UPD;
            S_UPD: begin
               if (query_ff == REQ_QUERY) acc_ff <= acc_ff & rd_ff;
               row_ff   <= row_ff + ROWS_W'(1);
               base_ff  <= base_ff + AW'(w_ff);
               state_ff <= S_ROW;
            end
            S_DONE: begin
               if (!rsp_valid_ff || rsp_ready) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_value_ff <= (query_ff == REQ_QUERY) ? acc_ff : 32'd0;
                  state_ff     <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_result_value = rsp_value_ff;

endmodule

### hw/rtl/vbs_checker.sv
// vbs_checker: port-level checks on the value bloom sketch, bound to the top level.
// Depends on value_bloom_sketch.
module vbs_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [31:0] rsp_result_value,
   input logic        pready
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result item dropped while stalled");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_result_value))
      else $error("result item changed while stalled");

   a_one_at_time: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while busy");

   a_after_reset: assert property (@(posedge clock)
      reset |=> !req_ready && !rsp_valid && pready)
      else $error("block not quiet after reset");

endmodule

bind value_bloom_sketch vbs_checker u_vbs_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_valid),
   .req_ready        (req_ready),
   .rsp_valid        (rsp_valid),
   .rsp_ready        (rsp_ready),
   .rsp_result_value (rsp_result_value),
   .pready           (pready)
);
